FILE: hdl/cla_pkg.sv
// cla_pkg: shared types and character codes for the console line assembler
// no dependencies
package cla_pkg;

	localparam int unsigned LEN_W  = 7;
	localparam int unsigned CHAR_W = 8;

	localparam logic [CHAR_W-1:0] CHR_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CHR_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CHR_SPACE     = 8'd32;
	localparam logic [CHAR_W-1:0] CHR_NUL       = 8'd0;

	localparam logic KIND_MSG = 1'b0;
	localparam logic KIND_OVF = 1'b1;

	// one job for the emitter: a finished line or an overflow warning
	typedef struct packed {
		logic             ovf;
		logic             bank;
		logic [LEN_W-1:0] len;
	} job_t;

	// write port into the line store
	typedef struct packed {
		logic              en;
		logic              bank;
		logic [LEN_W-1:0]  idx;
		logic [CHAR_W-1:0] data;
	} store_wr_t;

endpackage

FILE: hdl/cla_in_if.sv
// cla_in_if: received byte channel of the console line assembler
// depends on cla_pkg
interface cla_in_if import cla_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

FILE: hdl/cla_out_if.sv
// cla_out_if: result channel of the console line assembler
// depends on cla_pkg
interface cla_out_if import cla_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              out_kind;
	logic [CHAR_W-1:0] out_char;
	logic [LEN_W-1:0]  out_length;
	logic              out_last;

	modport source(output valid, output out_kind, output out_char, output out_length,
		output out_last, input ready);
	modport sink(input valid, input out_kind, input out_char, input out_length,
		input out_last, output ready);
endinterface

FILE: hdl/cla_queue.sv
// cla_queue: short job queue between the front and the emitter
// depends on cla_pkg
module cla_queue import cla_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);
	localparam int unsigned DEPTH = 4;
	localparam int unsigned PW    = $clog2(DEPTH);

	job_t            slots_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full       = (count_q == (PW+1)'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

FILE: hdl/cla_front.sv
// cla_front: takes bytes, edits the line, queues lines and overflows
// depends on cla_pkg and cla_in_if
module cla_front import cla_pkg::*; #(
	parameter int unsigned MSG_SIZE = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	cla_in_if.sink    din,
	output logic      q_push,
	output job_t      q_job,
	input  logic      q_full,
	output store_wr_t wr,
	input  logic      line_done
);
	logic [LEN_W-1:0] len_q;
	logic             bank_q;
	logic [1:0]       lines_q;
	logic             fire;
	logic             is_full;
	logic             is_skip;
	logic             is_bs;
	logic             is_cr;
	logic             line_push;

	assign din.ready = !q_full && (lines_q != 2'd2);
	assign fire      = din.valid && din.ready;

	assign is_full = (len_q >= LEN_W'(MSG_SIZE - 1));
	assign is_skip = (din.rx_byte == CHR_SPACE) && (len_q == '0);
	assign is_bs   = (din.rx_byte == CHR_BACKSPACE);
	assign is_cr   = (din.rx_byte == CHR_RETURN);

	assign line_push = fire && !is_full && !is_skip && !is_bs && is_cr;
	assign q_push    = fire && (is_full || line_push);

	always_comb begin
		q_job      = '0;
		q_job.ovf  = is_full;
		q_job.bank = bank_q;
		q_job.len  = is_full ? '0 : len_q;
	end

	always_comb begin
		wr      = '0;
		wr.en   = fire && !is_full && !is_skip && !is_bs && !is_cr;
		wr.bank = bank_q;
		wr.idx  = len_q;
		wr.data = din.rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			bank_q  <= 1'b0;
			lines_q <= '0;
		end else begin
			if (fire) begin
				priority if (is_full) begin
					len_q <= '0;
				end else if (is_skip) begin
					len_q <= len_q;
				end else if (is_bs) begin
					if (len_q != '0) begin
						len_q <= len_q - 1'b1;
					end
				end else if (is_cr) begin
					len_q  <= '0;
					bank_q <= !bank_q;
				end else begin
					len_q <= len_q + 1'b1;
				end
			end
			if (line_push && !line_done) begin
				lines_q <= lines_q + 1'b1;
			end else if (line_done && !line_push) begin
				lines_q <= lines_q - 1'b1;
			end
		end
	end
endmodule

FILE: hdl/cla_back.sv
// cla_back: line store and emitter that plays out queued jobs
// depends on cla_pkg and cla_out_if
module cla_back import cla_pkg::*; #(
	parameter int unsigned MSG_SIZE = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  store_wr_t wr,
	input  logic      head_valid,
	input  job_t      head_job,
	output logic      pop,
	output logic      line_done,
	cla_out_if.source dout
);
	localparam int unsigned AW    = (MSG_SIZE > 2) ? $clog2(MSG_SIZE) : 1;
	localparam int unsigned DEPTH = 2 * (2 ** AW);

	typedef enum logic [1:0] {
		IDLE,
		RUN,
		OVF
	} state_t;

	state_t            state_q;
	logic              bank_q;
	logic [LEN_W-1:0]  n_q;
	logic [LEN_W-1:0]  idx_q;
	logic [CHAR_W-1:0] mem [DEPTH];
	logic [CHAR_W-1:0] rdata_q;
	logic [AW:0]       rd_addr;
	logic [LEN_W-1:0]  rd_idx;
	logic              fire;
	logic              at_end;

	assign pop    = (state_q == IDLE) && head_valid;
	assign fire   = dout.valid && dout.ready;
	assign at_end = (idx_q == n_q);

	always_comb begin
		unique case (state_q)
			IDLE:    rd_idx = '0;
			RUN:     rd_idx = fire ? idx_q + 1'b1 : idx_q;
			default: rd_idx = idx_q;
		endcase
		rd_addr = (state_q == IDLE) ? {head_job.bank, rd_idx[AW-1:0]}
			: {bank_q, rd_idx[AW-1:0]};
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[{wr.bank, wr.idx[AW-1:0]}] <= wr.data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_comb begin
		dout.valid      = (state_q == RUN) || (state_q == OVF);
		dout.out_kind   = (state_q == OVF) ? KIND_OVF : KIND_MSG;
		dout.out_char   = (state_q == RUN && !at_end) ? rdata_q : CHR_NUL;
		dout.out_length = (state_q == RUN) ? n_q + 1'b1 : '0;
		dout.out_last   = (state_q == OVF) || at_end;
	end

	assign line_done = (state_q == RUN) && fire && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			bank_q  <= 1'b0;
			n_q     <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (head_valid) begin
						bank_q  <= head_job.bank;
						n_q     <= head_job.len;
						idx_q   <= '0;
						state_q <= head_job.ovf ? OVF : RUN;
					end
				end
				RUN: begin
					if (fire) begin
						if (at_end) begin
							state_q <= IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				OVF: begin
					if (fire) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

FILE: hdl/console_line_assembler.sv
// console_line_assembler: top level, front editor, job queue and line emitter
// depends on cla_pkg, cla_in_if, cla_out_if, cla_front, cla_queue, cla_back
// Accepts one console byte per cycle; short of a full line, spaces on an empty
// line, backspaces and ordinary characters give no result. A carriage return
// queues the line and the emitter then plays it out as one item per cycle
// while the output is ready, characters then a zero terminator. The first
// item of a line passes through the job queue and a registered fetch of the
// first character from the line store; an overflow gives one warning item
// through the same job queue, and the emitter goes idle between consecutive
// jobs. The store is double banked, so the editor keeps taking bytes into the
// next line while the previous one is emitted; it stalls only while two
// finished lines still wait to go out or the four-entry job queue is full.
module console_line_assembler import cla_pkg::*; #(
	parameter int unsigned MSG_SIZE = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	cla_in_if.sink    din,
	cla_out_if.source dout
);
	logic      q_push;
	job_t      q_job;
	logic      q_full;
	logic      q_pop;
	logic      q_valid;
	job_t      q_head;
	store_wr_t wr;
	logic      line_done;

	cla_front #(.MSG_SIZE(MSG_SIZE)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.q_push    (q_push),
		.q_job     (q_job),
		.q_full    (q_full),
		.wr        (wr),
		.line_done (line_done)
	);

	cla_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_job   (q_head)
	);

	cla_back #(.MSG_SIZE(MSG_SIZE)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.head_valid (q_valid),
		.head_job   (q_head),
		.pop        (q_pop),
		.line_done  (line_done),
		.dout       (dout)
	);
endmodule
